// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds the channel beat layouts, function codes, character codes and FSM states.
// No dependencies.
package tcw_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [15:0] read_data;
    logic        scrolled;
  } out_beat_t;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]  ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_SCROLL_END
  } state_t;

endpackage

// ===== rtl/tcw_in_if.sv =====
// Input channel of the text console writer: valid, ready and one command beat.
// Depends on tcw_pkg for the beat layout.
interface tcw_in_if;
  logic               valid;
  logic               ready;
  tcw_pkg::in_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
// Result channel of the text console writer: valid, ready and one result beat.
// Depends on tcw_pkg for the beat layout.
interface tcw_out_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/text_console_writer_top.sv =====
// Text console writer: screen buffer of character/attribute cells with a cursor.
// Depends on tcw_pkg, tcw_in_if and tcw_out_if.
//
//   port       dir  beat contents
//   in_chan    in   func, char_code, cell_address
//   out_chan   out  cursor_location, cursor_column, cursor_row, read_data, scrolled
//   cfg_we/data in  colour attribute, written when cfg_we is high out of reset
//
// A put character or an unused function gives its result from the idle state; a read
// first passes a read state, set by the registered read port of the screen memory.
// Clear and a scrolling put walk the memory one cell per cycle; a scroll moves each row
// up, blanking the last. After reset a clearing pass runs before any beat is taken.
// One command is in flight at a time; a result register and a skid stage let a new
// command enter while a finished result waits on a stalled output.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  tcw_in_if.sink     in_chan,
  tcw_out_if.source  out_chan
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 8);
  localparam int LW    = $clog2(ROWS + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LIMIT = CW'(COLUMNS);
  localparam logic [LW-1:0] ROW_LIMIT = LW'(ROWS);
  localparam logic [LW-1:0] ROW_LAST  = LW'(ROWS - 1);

  logic [15:0] screen_mem [CELLS];

  tcw_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic               clr_push_r, clr_push_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [LW-1:0]      line_r, line_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [7:0]         attr_r;
  logic [15:0]        rd_data_r;
  logic               cp_v_r;
  logic [AW-1:0]      cp_a_r;
  logic               cp_blank_r;
  tcw_pkg::out_beat_t out_r, skid_r, res;
  logic               out_valid_r, skid_valid_r;

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [15:0]        mem_wd;
  logic [AW-1:0]      rd_addr;
  logic               in_ready;
  logic               push;
  logic [15:0]        push_rdata;
  logic               push_scrolled;
  logic [CW-1:0]      c_col;
  logic [LW-1:0]      c_line;
  logic [AW-1:0]      row_base;
  logic [7:0]         ch;

  assign ch       = in_chan.payload.char_code;
  assign row_base = AW'(line_r) * COL_STEP;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    clr_push_nxt  = clr_push_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    rd_ok_nxt     = rd_ok_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = tcw_pkg::BLANK_CELL;
    rd_addr       = AW'(in_chan.payload.cell_address);
    in_ready      = 1'b0;
    push          = 1'b0;
    push_rdata    = '0;
    push_scrolled = 1'b0;
    c_col         = col_r;
    c_line        = line_r;

    case (state_r)
      tcw_pkg::ST_IDLE: begin
        in_ready = !skid_valid_r;
        if (in_chan.valid && in_ready) begin
          case (in_chan.payload.func)
            tcw_pkg::FUNC_PUT: begin
              case (ch)
                tcw_pkg::CH_BS: begin
                  if (col_r != '0) begin
                    c_col  = col_r - 1'b1;
                    mem_we = 1'b1;
                    mem_wa = row_base + AW'(c_col);
                    mem_wd = {attr_r, tcw_pkg::CH_SPACE};
                  end
                end
                tcw_pkg::CH_TAB: c_col = (col_r + CW'(8)) & ~CW'(7);
                tcw_pkg::CH_CR:  c_col = '0;
                tcw_pkg::CH_LF: begin
                  c_col  = '0;
                  c_line = line_r + 1'b1;
                end
                default: begin
                  if (ch inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_DEL]}) begin
                    mem_we = 1'b1;
                    mem_wa = row_base + AW'(col_r);
                    mem_wd = {attr_r, ch};
                    c_col  = col_r + 1'b1;
                  end
                end
              endcase
              if (c_col >= COL_LIMIT) begin
                c_col  = '0;
                c_line = c_line + 1'b1;
              end
              col_nxt = c_col;
              if (c_line >= ROW_LIMIT) begin
                line_nxt  = ROW_LAST;
                k_nxt     = '0;
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                line_nxt = c_line;
                push     = 1'b1;
              end
            end
            tcw_pkg::FUNC_CLEAR: begin
              col_nxt      = '0;
              line_nxt     = '0;
              k_nxt        = '0;
              clr_push_nxt = 1'b1;
              state_nxt    = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::FUNC_READ: begin
              rd_ok_nxt = int'(in_chan.payload.cell_address) < CELLS;
              state_nxt = tcw_pkg::ST_READ;
            end
            default: push = 1'b1;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        push       = 1'b1;
        push_rdata = rd_ok_r ? rd_data_r : '0;
        state_nxt  = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = k_r;
        mem_wd = tcw_pkg::BLANK_CELL;
        if (k_r == LAST_CELL) begin
          push         = clr_push_r;
          clr_push_nxt = 1'b0;
          state_nxt    = tcw_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        rd_addr = k_r + COL_STEP;
        if (k_r == LAST_CELL) begin
          state_nxt = tcw_pkg::ST_SCROLL_END;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      tcw_pkg::ST_SCROLL_END: begin
        push          = 1'b1;
        push_scrolled = 1'b1;
        state_nxt     = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase

    // The copy write lands in the cycle after its read; the bottom row is blanked instead.
    if (cp_v_r) begin
      mem_we = 1'b1;
      mem_wa = cp_a_r;
      mem_wd = cp_blank_r ? tcw_pkg::BLANK_CELL : rd_data_r;
    end

    res.cursor_location = 11'(AW'(line_nxt) * COL_STEP + AW'(col_nxt));
    res.cursor_column   = 7'(col_nxt);
    res.cursor_row      = 5'(line_nxt);
    res.read_data       = push_rdata;
    res.scrolled        = push_scrolled;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= screen_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cp_a_r     <= k_r;
    cp_blank_r <= k_r >= COPY_END;
    if (!rst_n) begin
      state_r    <= tcw_pkg::ST_CLEAR;
      k_r        <= '0;
      clr_push_r <= 1'b0;
      col_r      <= '0;
      line_r     <= '0;
      rd_ok_r    <= 1'b0;
      attr_r     <= tcw_pkg::ATTR_RESET;
      cp_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      clr_push_r <= clr_push_nxt;
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      rd_ok_r    <= rd_ok_nxt;
      cp_v_r     <= state_r == tcw_pkg::ST_SCROLL;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

endmodule
